@@ design/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the ranked sequence store
// Item structs, command and status codes, and the control word that the
// store broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_PRINT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_FULL    = 2'd2,
    STS_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] position;
    logic [7:0] element;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  // Broadcast to all cells: operation, zero-based rank, live element count,
  // element to insert.
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] rank;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       elem;
  } cell_ctl_t;

endpackage

@@ design/rss_cell.sv @@
// ----------------------------------------------------------------------------
// rss_cell: one storage cell of the ranked sequence chain
// Holds one byte and, per the broadcast control word, keeps it or takes the
// element or left neighbor (insert), right neighbor (delete, rotate) or head.
// ----------------------------------------------------------------------------
module rss_cell (
  input  logic                    clk,
  input  logic [rss_pkg::IDX_W-1:0] idx,
  input  rss_pkg::cell_ctl_t      ctl,
  input  logic [7:0]              left_val,
  input  logic [7:0]              right_val,
  input  logic [7:0]              head_val,
  output logic [7:0]              val
);

  logic [7:0]              val_r;
  logic [7:0]              val_nxt;
  logic [rss_pkg::CNT_W-1:0] pos1;

  assign pos1 = rss_pkg::CNT_W'(idx) + rss_pkg::CNT_W'(1);

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      rss_pkg::OP_HOLD: val_nxt = val_r;
      rss_pkg::OP_INS: begin
        if (idx == ctl.rank) val_nxt = ctl.elem;
        else if (idx > ctl.rank) val_nxt = left_val;
      end
      rss_pkg::OP_DEL: begin
        if (idx >= ctl.rank) val_nxt = right_val;
      end
      rss_pkg::OP_ROT: begin
        // last live cell wraps around to the head
        if (pos1 == ctl.cnt) val_nxt = head_val;
        else if (pos1 < ctl.cnt) val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ design/ranked_sequence_store_top.sv @@
// ----------------------------------------------------------------------------
// ranked_sequence_store_top: ordered byte sequence addressed by rank
// Elements live in a chain of cells in rank order. Insert and delete shift
// the chain; get and print rotate the whole live chain once.
//
//   channel  ports                         direction  payload
//   in       in_valid in_ready in_item     input      in_item_t
//   out      out_valid out_ready out_item  output     out_item_t
//
// Get and print are accepted, then the chain rotates one cell per cycle
// while the output is not stalled and results are read at the head cell,
// so the chain is back in order at the end.
// No new item is taken during a rotation or while a result waits in the
// output register; a stalled output pauses the rotation.
// Reset empties the store (count to zero); cell contents are not cleared.
// ----------------------------------------------------------------------------
module ranked_sequence_store_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rss_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rss_pkg::out_item_t  out_item
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } fsm_t;

  fsm_t                       state_r, state_nxt;
  logic [rss_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [rss_pkg::IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [rss_pkg::IDX_W-1:0]  scan_rank_r, scan_rank_nxt;
  logic                       scan_print_r, scan_print_nxt;
  logic                       out_valid_r, out_valid_nxt;
  rss_pkg::out_item_t         out_item_r, out_item_nxt;

  rss_pkg::cell_ctl_t         ctl;
  logic [7:0]                 cell_val [rss_pkg::CAPACITY];

  logic                       out_free;
  logic                       in_fire;
  logic [8:0]                 pos9;
  logic [8:0]                 cnt9;
  logic                       pos_zero;
  logic                       bad_add;
  logic                       bad_rank;
  logic                       full;
  logic [7:0]                 pos_m1;
  logic [rss_pkg::CNT_W-1:0]  scan_pos1;
  logic                       scan_end;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;

  assign pos9      = {1'b0, in_item.position};
  assign cnt9      = 9'(cnt_r);
  assign pos_zero  = (in_item.position == 8'd0);
  assign bad_add   = pos_zero || (pos9 > cnt9 + 9'd1);
  assign bad_rank  = pos_zero || (pos9 > cnt9);
  assign full      = (cnt_r == rss_pkg::CNT_W'(rss_pkg::CAPACITY));
  assign pos_m1    = in_item.position - 8'd1;
  assign scan_pos1 = rss_pkg::CNT_W'(scan_idx_r) + rss_pkg::CNT_W'(1);
  assign scan_end  = (scan_pos1 == cnt_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    scan_rank_nxt  = scan_rank_r;
    scan_print_nxt = scan_print_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    ctl.op         = rss_pkg::OP_HOLD;
    ctl.rank       = pos_m1[rss_pkg::IDX_W-1:0];
    ctl.cnt        = cnt_r;
    ctl.elem       = in_item.element;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item.cmd)
            rss_pkg::CMD_ADD: begin
              if (bad_add || full) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = bad_add ? rss_pkg::STS_BAD_POS : rss_pkg::STS_FULL;
                out_item_nxt.data   = 8'd0;
                out_item_nxt.last   = 1'b1;
              end else begin
                ctl.op  = rss_pkg::OP_INS;
                cnt_nxt = cnt_r + rss_pkg::CNT_W'(1);
              end
            end
            rss_pkg::CMD_DELETE: begin
              if (bad_rank) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = rss_pkg::STS_BAD_POS;
                out_item_nxt.data   = 8'd0;
                out_item_nxt.last   = 1'b1;
              end else begin
                ctl.op  = rss_pkg::OP_DEL;
                cnt_nxt = cnt_r - rss_pkg::CNT_W'(1);
              end
            end
            rss_pkg::CMD_GET: begin
              if (bad_rank) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = rss_pkg::STS_BAD_POS;
                out_item_nxt.data   = 8'd0;
                out_item_nxt.last   = 1'b1;
              end else begin
                state_nxt      = ST_SCAN;
                scan_idx_nxt   = '0;
                scan_rank_nxt  = pos_m1[rss_pkg::IDX_W-1:0];
                scan_print_nxt = 1'b0;
              end
            end
            rss_pkg::CMD_PRINT: begin
              if (cnt_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = rss_pkg::STS_EMPTY;
                out_item_nxt.data   = 8'd0;
                out_item_nxt.last   = 1'b1;
              end else begin
                state_nxt      = ST_SCAN;
                scan_idx_nxt   = '0;
                scan_print_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // advance the rotation only when the output register can take a result
        if (out_free) begin
          ctl.op = rss_pkg::OP_ROT;
          if (scan_print_r || (scan_idx_r == scan_rank_r)) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = rss_pkg::STS_OK;
            out_item_nxt.data   = cell_val[0];
            out_item_nxt.last   = scan_print_r ? scan_end : 1'b1;
          end
          if (scan_end) begin
            state_nxt = ST_IDLE;
          end else begin
            scan_idx_nxt = scan_idx_r + rss_pkg::IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    scan_rank_r  <= scan_rank_nxt;
    scan_print_r <= scan_print_nxt;
    out_item_r   <= out_item_nxt;
  end

  for (genvar i = 0; i < rss_pkg::CAPACITY; i++) begin : g_cell
    logic [7:0] left_v;
    logic [7:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = 8'd0;
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == rss_pkg::CAPACITY - 1) begin : g_end
      assign right_v = 8'd0;
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end
    rss_cell u_cell (
      .clk       (clk),
      .idx       (rss_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rss_pkg::CNT_W'(rss_pkg::CAPACITY))
    else $error("element count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rss_pkg::CNT_W'(scan_idx_r) < cnt_r))
    else $error("scan index beyond live elements");

  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(cnt_r))
    else $error("count changed without an accepted item");

  a_no_take_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !in_ready)
    else $error("input taken during rotation");
`endif

endmodule
